// ----- sv/serial_command_line_parser_unit_assert.svh -----
// Assertion macros for the serial command line parser.
`ifndef SERIAL_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH
`define SERIAL_COMMAND_LINE_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define SCLP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sclp assertion failed");
// checked on every edge
`define SCLP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("sclp assertion failed");
`else
`define SCLP_ASSERT(label, clk, rst, prop)
`define SCLP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ----- sv/sclp_pkg.sv -----
package sclp_pkg;

   localparam int LINE_MAX     = 65;
   localparam int NUM_KEYWORDS = 10;
   localparam int KEYWORD_MAX  = 8;
   localparam int KW_IDX_W     = $clog2(KEYWORD_MAX);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [15:0] TIMEOUT_RESET = 16'd100;
   localparam logic [15:0] TICKS_MAX     = 16'hFFFF;
   localparam logic [5:0]  TOKENS_MAX    = 6'd63;
   localparam logic [6:0]  TOKLEN_MAX    = 7'd127;

   localparam logic [7:0] CH_NUL      = 8'h00;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_PRINT_LO = 8'h1F;
   localparam logic [7:0] CH_PRINT_HI = 8'h7F;
   localparam logic [7:0] CASE_DIFF   = 8'h20;

   localparam logic [1:0] STATUS_MATCH    = 2'd0;
   localparam logic [1:0] STATUS_UNKNOWN  = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;

   // first token tracking
   localparam logic [1:0] PHASE_BEFORE = 2'd0;
   localparam logic [1:0] PHASE_IN     = 2'd1;
   localparam logic [1:0] PHASE_DONE   = 2'd2;

   localparam logic [7:0] KW_TEXT [NUM_KEYWORDS][KEYWORD_MAX] = '{
      '{"t", "r", "a", "i", "n", 8'h00, 8'h00, 8'h00},
      '{"l", "o", "a", "d", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"c", "l", "e", "a", "r", 8'h00, 8'h00, 8'h00},
      '{"v", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "c", "o", "r", "d", 8'h00, 8'h00},
      '{"s", "i", "g", "t", "r", "a", "i", "n"},
      '{"g", "e", "t", "s", "i", "g", 8'h00, 8'h00},
      '{"S", "e", "t", "t", "i", "n", "g", "s"},
      '{"t", "e", "s", "t", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"h", "e", "l", "p", 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [6:0] KW_LEN [NUM_KEYWORDS] = '{
      7'd5, 7'd4, 7'd5, 7'd2, 7'd6, 7'd8, 7'd6, 7'd8, 7'd4, 7'd4
   };

   // classified input beat
   typedef struct packed {
      logic       tick;
      logic [7:0] data;
      logic       sep;      // tab, space, CR, LF
      logic       blank;    // tab, space
      logic       ok;       // printable or separator
      logic       newline;
   } beat_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] command_index;
      logic [5:0] token_count;
      logic [6:0] line_length;
   } rsp_type;

   // equal, or differing by 0x20 either way (mod 256)
   function automatic logic letter_eq(logic [7:0] b, logic [7:0] k);
      logic [7:0] d1;
      logic [7:0] d2;
      d1 = k - b;
      d2 = b - k;
      return (d1 == 8'h00) || (d1 == CASE_DIFF) || (d2 == CASE_DIFF);
   endfunction

endpackage

// ----- sv/sclp_front.sv -----
module sclp_front
   import sclp_pkg::*;
(
   input  logic       req_push,
   input  logic       req_mode,
   input  logic [7:0] req_data_byte,
   input  logic       q_full,
   output logic       q_push,
   output beat_type   q_beat
);

   logic is_nul;

   always_comb begin
      q_beat.tick    = req_mode;
      q_beat.data    = req_data_byte;
      q_beat.blank   = (req_data_byte == CH_TAB) || (req_data_byte == CH_SPACE);
      q_beat.newline = (req_data_byte == CH_LF);
      q_beat.sep     = q_beat.blank || q_beat.newline || (req_data_byte == CH_CR);
      q_beat.ok      = ((req_data_byte > CH_PRINT_LO) && (req_data_byte < CH_PRINT_HI))
                       || q_beat.sep;
   end

   // NUL bytes vanish here; they do not even restart the idle count
   assign is_nul = !req_mode && (req_data_byte == CH_NUL);
   assign q_push = req_push && !q_full && !is_nul;

endmodule

// ----- sv/sclp_queue.sv -----
module sclp_queue
   import sclp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  beat_type beat_in,
   input  logic     pop,
   output logic     full,
   output logic     valid,
   output beat_type beat_out
);

   beat_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign beat_out = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= beat_in;
      end
   end

endmodule

// ----- sv/sclp_back.sv -----
`include "serial_command_line_parser_unit_assert.svh"

module sclp_back
   import sclp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  beat_type    q_beat,
   output logic        q_pop,
   input  logic        csr_valid,
   input  logic [15:0] csr_wdata,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp
);

   logic [15:0]             timeout_ff, timeout_in;
   logic [15:0]             idle_ff, idle_in;
   logic [6:0]              byte_count_ff, byte_count_in;
   logic                    bad_ff, bad_in;
   logic [5:0]              tokens_ff, tokens_in;
   logic                    inside_ff, inside_in;
   logic [1:0]              phase_ff, phase_in;
   logic [6:0]              ftl_ff, ftl_in;
   logic [NUM_KEYWORDS-1:0] flags_ff, flags_in;

   rsp_type                 out_mem_ff [2];
   logic                    out_wr_ff, out_wr_in;
   logic                    out_rd_ff, out_rd_in;
   logic [1:0]              out_cnt_ff, out_cnt_in;

   logic        out_full;
   logic        makes_rsp;
   logic        out_push;
   logic        out_pop;
   logic        clear;
   logic        feed;
   logic        found;
   logic        fresh_token;
   logic [15:0] idle_inc;
   logic [6:0]  bc_next;
   rsp_type     result;

   assign out_full  = (out_cnt_ff == 2'd2);
   assign makes_rsp = !q_beat.tick && q_beat.newline;
   assign q_pop     = q_valid && (!out_full || !makes_rsp);
   assign out_push  = q_pop && makes_rsp;
   assign out_pop   = rsp_pop && (out_cnt_ff != 2'd0);
   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp       = out_mem_ff[out_rd_ff];
   assign idle_inc  = (idle_ff == TICKS_MAX) ? idle_ff : idle_ff + 16'd1;
   assign bc_next   = byte_count_ff + 7'd1;

   // result of a newline beat; the newline itself leaves the line state unchanged
   always_comb begin
      found                = 1'b0;
      result.status        = bad_ff ? STATUS_BAD_CHAR : STATUS_UNKNOWN;
      result.command_index = 4'd0;
      result.token_count   = tokens_ff;
      result.line_length   = bc_next;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         if (!found && flags_ff[k] && (KW_LEN[k] != 7'd0) && (KW_LEN[k] == ftl_ff)) begin
            found = 1'b1;
            if (!bad_ff) begin
               result.status        = STATUS_MATCH;
               result.command_index = 4'(k);
            end
         end
      end
   end

   always_comb begin
      timeout_in    = timeout_ff;
      idle_in       = idle_ff;
      byte_count_in = byte_count_ff;
      bad_in        = bad_ff;
      tokens_in     = tokens_ff;
      inside_in     = inside_ff;
      phase_in      = phase_ff;
      ftl_in        = ftl_ff;
      flags_in      = flags_ff;
      clear         = 1'b0;
      feed          = 1'b0;

      if (csr_valid) begin
         timeout_in = csr_wdata;
      end

      if (q_pop) begin
         if (q_beat.tick) begin
            if (idle_inc > timeout_ff) begin
               clear   = 1'b1;
               idle_in = 16'd0;
            end else begin
               idle_in = idle_inc;
            end
         end else begin
            idle_in = 16'd0;
            bad_in  = bad_ff || !q_beat.ok;

            if (!q_beat.sep) begin
               if (!inside_ff && (tokens_ff < TOKENS_MAX)) begin
                  tokens_in = tokens_ff + 6'd1;
               end
               inside_in = 1'b1;
            end else begin
               inside_in = 1'b0;
            end

            case (phase_ff)
               PHASE_BEFORE: begin
                  if (q_beat.blank) begin
                     phase_in = PHASE_BEFORE;
                  end else if (q_beat.sep) begin
                     phase_in = PHASE_DONE;
                  end else begin
                     phase_in = PHASE_IN;
                     feed     = 1'b1;
                  end
               end
               PHASE_IN: begin
                  if (q_beat.sep) begin
                     phase_in = PHASE_DONE;
                  end else begin
                     feed = 1'b1;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase

            if (feed) begin
               for (int k = 0; k < NUM_KEYWORDS; k++) begin
                  if (!((ftl_ff < 7'(KEYWORD_MAX)) && (ftl_ff < KW_LEN[k]) &&
                        letter_eq(q_beat.data, KW_TEXT[k][ftl_ff[KW_IDX_W-1:0]]))) begin
                     flags_in[k] = 1'b0;
                  end
               end
               if (ftl_ff < TOKLEN_MAX) begin
                  ftl_in = ftl_ff + 7'd1;
               end
            end

            if (q_beat.newline) begin
               clear = 1'b1;
            end else begin
               byte_count_in = bc_next;
               if (bc_next >= 7'(LINE_MAX)) begin
                  clear = 1'b1;
               end
            end
         end

         if (clear) begin
            byte_count_in = 7'd0;
            bad_in        = 1'b0;
            tokens_in     = 6'd0;
            inside_in     = 1'b0;
            phase_in      = PHASE_BEFORE;
            ftl_in        = 7'd0;
            flags_in      = '1;
         end
      end
   end

   always_comb begin
      out_wr_in  = out_push ? !out_wr_ff : out_wr_ff;
      out_rd_in  = out_pop ? !out_rd_ff : out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (out_push && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (out_pop && !out_push) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         idle_ff       <= 16'd0;
         byte_count_ff <= 7'd0;
         bad_ff        <= 1'b0;
         tokens_ff     <= 6'd0;
         inside_ff     <= 1'b0;
         phase_ff      <= PHASE_BEFORE;
         ftl_ff        <= 7'd0;
         flags_ff      <= '1;
         out_wr_ff     <= 1'b0;
         out_rd_ff     <= 1'b0;
         out_cnt_ff    <= 2'd0;
      end else begin
         timeout_ff    <= timeout_in;
         idle_ff       <= idle_in;
         byte_count_ff <= byte_count_in;
         bad_ff        <= bad_in;
         tokens_ff     <= tokens_in;
         inside_ff     <= inside_in;
         phase_ff      <= phase_in;
         ftl_ff        <= ftl_in;
         flags_ff      <= flags_in;
         out_wr_ff     <= out_wr_in;
         out_rd_ff     <= out_rd_in;
         out_cnt_ff    <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= result;
      end
   end

   assign fresh_token = (ftl_ff == 7'd0) && (flags_ff == '1);

   `SCLP_ASSERT(a_line_below_max, clock, reset, byte_count_ff < 7'(LINE_MAX))
   `SCLP_ASSERT(a_fresh_token_state, clock, reset, (phase_ff == PHASE_BEFORE) |-> fresh_token)
   `SCLP_ASSERT(a_out_bound, clock, reset, out_cnt_ff <= 2'd2)
   `SCLP_ASSERT(a_rsp_lands, clock, reset, out_push |=> !rsp_empty)

endmodule

// ----- sv/serial_command_line_parser_unit.sv -----
// A newline beat accepted at the port is registered in the beat queue and then in the
// result buffer before it shows on the rsp_ ports; it waits while the result side stalls.
// Throughput: one beat (byte or tick) per cycle, set by the back end's one update a cycle,
// while the result buffer has room; a full result buffer holds back newline beats.
// Reset: synchronous, active high; clears the line, the idle count and both
// queues, and sets idle_timeout to 100.
`include "serial_command_line_parser_unit_assert.svh"

module serial_command_line_parser_unit
   import sclp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_mode,
   input  logic [7:0]  req_data_byte,
   // results
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_command_index,
   output logic [5:0]  rsp_token_count,
   output logic [6:0]  rsp_line_length,
   // idle_timeout register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_wdata
);

   // front -> queue -> back
   logic     q_push;
   logic     q_full;
   logic     q_valid;
   logic     q_pop;
   beat_type front_beat;
   beat_type head_beat;
   rsp_type  rsp;

   // assertion helpers
   logic     req_taken;
   logic     status_legal;
   logic     no_match_shown;

   // the register must be written only while the block is quiet, unchecked; always take it
   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   // front end: classify each byte, drop NUL bytes
   sclp_front u_front (
      .req_push      (req_push),
      .req_mode      (req_mode),
      .req_data_byte (req_data_byte),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_beat        (front_beat)
   );

   // short decoupling queue so either side can stall alone
   sclp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .beat_in  (front_beat),
      .pop      (q_pop),
      .full     (q_full),
      .valid    (q_valid),
      .beat_out (head_beat)
   );

   // back end: line state, keyword match, result register
   sclp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_beat    (head_beat),
      .q_pop     (q_pop),
      .csr_valid (csr_valid),
      .csr_wdata (csr_wdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_status        = rsp.status;
   assign rsp_command_index = rsp.command_index;
   assign rsp_token_count   = rsp.token_count;
   assign rsp_line_length   = rsp.line_length;

   assign req_taken      = req_push && !req_full && (req_mode || (req_data_byte != CH_NUL));
   assign status_legal   = (rsp_status == STATUS_MATCH) || (rsp_status == STATUS_UNKNOWN) ||
                           (rsp_status == STATUS_BAD_CHAR);
   assign no_match_shown = !rsp_empty && (rsp_status != STATUS_MATCH);

   // a beat taken at the port either enters the queue or was a NUL byte
   `SCLP_ASSERT(a_accept_enqueues, clock, reset, req_taken |-> q_push)
   // a shown result carries one of the three status codes
   `SCLP_ASSERT(a_status_code, clock, reset, !rsp_empty |-> status_legal)
   // only a matched line carries a command index
   `SCLP_ASSERT(a_index_only_on_match, clock, reset, no_match_shown |-> (rsp_command_index == 4'd0))

endmodule

// ----- test/testbench.sv -----
module testbench;
   import sclp_pkg::*;

   localparam int LINE_LIMIT    = 65;     // bytes after which a line is dropped
   localparam int KW_COUNT      = 10;
   localparam int KW_CHARS      = 8;      // longest keyword the matcher follows
   localparam int SETTLE_CYCLES = 8;      // beat queue plus result register, with margin
   localparam int DRAIN_LIMIT   = 5000;
   localparam int PHASE_BEATS   = 130;

   // one line result as seen on the rsp_ ports
   typedef struct packed {
      logic [1:0] status;
      logic [3:0] cmd;
      logic [5:0] tokens;
      logic [6:0] length;
   } line_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_mode = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_command_index;
   logic [5:0]  rsp_token_count;
   logic [6:0]  rsp_line_length;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_wdata = 16'h0000;

   // line state tracked by the testbench
   bit [15:0]   timeout_reg;
   int unsigned tick_count;
   int unsigned line_len;
   bit          bad_seen;
   int unsigned tokens;
   bit          mid_token;
   logic [1:0]  first_phase;
   int unsigned first_len;
   bit [KW_COUNT-1:0] kw_alive;

   line_result_type pending_results[$];

   int error_count = 0;
   int beats_sent  = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   serial_command_line_parser_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_mode          (req_mode),
      .req_data_byte     (req_data_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_status        (rsp_status),
      .rsp_command_index (rsp_command_index),
      .rsp_token_count   (rsp_token_count),
      .rsp_line_length   (rsp_line_length),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Command line tracker
   // ------------------------------------------------------------------

   function automatic string kw_name(input int k);
      case (k)
         0: return "train";
         1: return "load";
         2: return "clear";
         3: return "vr";
         4: return "record";
         5: return "sigtrain";
         6: return "getsig";
         7: return "Settings";
         8: return "test";
         default: return "help";
      endcase
   endfunction

   function automatic bit is_gap(input bit [7:0] b);
      return b == CH_TAB || b == CH_SPACE || b == CH_CR || b == CH_LF;
   endfunction

   // case folding is plain +/- 0x20 arithmetic, wrapping at 8 bits
   function automatic bit folds_to(input bit [7:0] b, input bit [7:0] k);
      return b == k || b == k + 8'h20 || b == k - 8'h20;
   endfunction

   function automatic void start_line();
      line_len    = 0;
      bad_seen    = 1'b0;
      tokens      = 0;
      mid_token   = 1'b0;
      first_phase = PHASE_BEFORE;
      first_len   = 0;
      kw_alive    = '1;
   endfunction

   function automatic void track_reset();
      timeout_reg = 16'd100;
      tick_count  = 0;
      start_line();
   endfunction

   // one more character of the first token: prune the keyword candidates
   function automatic void grow_first_token(input bit [7:0] b);
      string kw;
      for (int k = 0; k < KW_COUNT; k++) begin
         kw = kw_name(k);
         if (kw_alive[k] && !(first_len < KW_CHARS && first_len < kw.len()
                              && folds_to(b, kw[first_len])))
            kw_alive[k] = 1'b0;
      end
      if (first_len < 127)
         first_len++;
   endfunction

   // apply one accepted beat; a newline queues the line's result
   function automatic void track_beat(input bit mode, input bit [7:0] b);
      line_result_type r;
      bit gap;
      string kw;
      if (mode) begin
         if (tick_count < 65535)
            tick_count++;
         if (tick_count > timeout_reg) begin
            start_line();
            tick_count = 0;
         end
         return;
      end
      if (b == CH_NUL)
         return;              // NUL is dropped and does not restart the idle count
      tick_count = 0;
      gap = is_gap(b);
      if (!gap && (b < 8'h20 || b > 8'h7E))
         bad_seen = 1'b1;
      if (!gap) begin
         if (!mid_token && tokens < 63)
            tokens++;
         mid_token = 1'b1;
      end else begin
         mid_token = 1'b0;
      end

      case (first_phase)
         PHASE_BEFORE: begin
            if (b == CH_CR || b == CH_LF) begin
               first_phase = PHASE_DONE;     // empty first token
            end else if (b != CH_TAB && b != CH_SPACE) begin
               first_phase = PHASE_IN;
               grow_first_token(b);
            end
         end
         PHASE_IN: begin
            if (gap)
               first_phase = PHASE_DONE;
            else
               grow_first_token(b);
         end
         default: ;
      endcase

      if (b == CH_LF) begin
         r.status = STATUS_UNKNOWN;
         r.cmd    = 4'd0;
         if (bad_seen) begin
            r.status = STATUS_BAD_CHAR;
         end else begin
            for (int k = KW_COUNT - 1; k >= 0; k--) begin
               kw = kw_name(k);
               if (kw_alive[k] && kw.len() == first_len) begin
                  r.status = STATUS_MATCH;
                  r.cmd    = k[3:0];
               end
            end
         end
         r.tokens = tokens[5:0];
         r.length = 7'(line_len + 1);
         pending_results.push_back(r);
         start_line();
         return;
      end

      line_len++;
      if (line_len >= LINE_LIMIT)
         start_line();       // overlong line, dropped without a result
   endfunction

   // ------------------------------------------------------------------
   // Result side: random stalls, every popped result checked in order
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= 40)
         $display("mismatch: %s", msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin : result_check
            line_result_type want;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result with none pending, status %0d length %0d",
                                         rsp_status, rsp_line_length));
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("field status got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_command_index !== want.cmd)
                  report_mismatch($sformatf("field command_index got %0d want %0d",
                                            rsp_command_index, want.cmd));
               if (rsp_token_count !== want.tokens)
                  report_mismatch($sformatf("field token_count got %0d want %0d",
                                            rsp_token_count, want.tokens));
               if (rsp_line_length !== want.length)
                  report_mismatch($sformatf("field line_length got %0d want %0d",
                                            rsp_line_length, want.length));
            end
         end
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------

   // one beat; push stays high into the next call unless it idles first
   task automatic send_beat(input bit mode, input bit [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_mode      <= mode;
      req_data_byte <= b;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      track_beat(mode, b);
      if (mode || b != CH_NUL)
         beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_beat(1'b0, s[i]);
   endtask

   task automatic send_ticks(input int n);
      repeat (n)
         send_beat(1'b1, 8'($urandom));
   endtask

   // sender holds off until every queued line result has been popped
   task automatic wait_for_results();
      int n;
      n = 0;
      req_push <= 1'b0;
      while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      if (pending_results.size() != 0) begin
         report_mismatch($sformatf("%0d line results never arrived",
                                   pending_results.size()));
         pending_results.delete();
      end
   endtask

   // register writes only with the block idle; non-newline beats may still be
   // in the beat queue when the last result pops, hence the settle time
   task automatic write_timeout(input bit [15:0] v);
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      timeout_reg = v;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Random line generation
   // ------------------------------------------------------------------

   function automatic bit [7:0] case_variant(input bit [7:0] c);
      int r;
      r = $urandom_range(9);
      if (r < 5) return c;
      if (r < 8) return c ^ 8'h20;
      if (r == 8) return c - 8'h20;
      return c + 8'h20;
   endfunction

   function automatic bit [7:0] bad_byte();
      bit [7:0] b;
      do
         b = 8'($urandom_range(1, 255));
      while (is_gap(b) || (b >= 8'h20 && b <= 8'h7E));
      return b;
   endfunction

   function automatic bit [7:0] blank_byte();
      return $urandom_range(1) ? CH_SPACE : CH_TAB;
   endfunction

   // mostly well formed command lines with random content; some carry bad
   // bytes, NULs, overlong bodies or an idle gap in the middle
   task automatic send_random_line();
      bit [7:0] body[$];
      string kw;
      int pick, cut, burst;
      body = {};
      repeat ($urandom_range(0, 2))
         body.push_back(blank_byte());
      pick = $urandom_range(99);
      if (pick < 65) begin
         kw = kw_name($urandom_range(KW_COUNT - 1));
         for (int i = 0; i < kw.len(); i++)
            body.push_back(case_variant(kw[i]));
         if (pick < 5)
            body.push_back(8'($urandom_range(8'h21, 8'h7E)));
         else if (pick < 10)
            void'(body.pop_back());
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 10))
            body.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
      cut = body.size();
      repeat ($urandom_range(0, 4)) begin
         repeat ($urandom_range(1, 2))
            body.push_back(blank_byte());
         repeat ($urandom_range(1, 8))
            body.push_back(8'($urandom_range(8'h21, 8'h7E)));
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
         while (body.size() < 70)
            body.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 7) begin
         while (body.size() < 64)
            body.push_back(8'($urandom_range(8'h20, 8'h7E)));
      end
      if (body.size() != 0 && $urandom_range(9) == 0)
         body[$urandom_range(body.size() - 1)] = bad_byte();
      if (body.size() != 0 && $urandom_range(19) == 0)
         body[$urandom_range(body.size() - 1)] = CH_NUL;
      if ($urandom_range(4) == 0 && body.size() < 64)
         body.push_back(CH_CR);

      // idle gap length: sometimes past the timeout, when that is affordable
      burst = 0;
      if ($urandom_range(99) < 15) begin
         if (timeout_reg <= 60)
            burst = $urandom_range(1, timeout_reg + 2);
         else if ($urandom_range(9) == 0 && timeout_reg <= 200)
            burst = $urandom_range(timeout_reg, timeout_reg + 2);
         else
            burst = $urandom_range(1, 5);
      end

      for (int i = 0; i < body.size(); i++) begin
         if (i == cut)
            send_ticks(burst);
         send_beat(1'b0, body[i]);
      end
      if (cut >= body.size())
         send_ticks(burst);
      send_beat(1'b0, CH_LF);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // every keyword, odd ones case flipped, plus the digit that folds to 'S'
   task automatic test_keyword_table();
      string kw;
      for (int k = 0; k < KW_COUNT; k++) begin
         kw = kw_name(k);
         for (int i = 0; i < kw.len(); i++)
            send_beat(1'b0, (k % 2) ? kw[i] ^ 8'h20 : kw[i]);
         send_beat(1'b0, CH_LF);
      end
      send_text("3ETTINGS");
      send_beat(1'b0, CH_LF);
   endtask

   task automatic test_line_forms();
      send_beat(1'b0, CH_LF);                  // empty line
      send_beat(1'b0, CH_SPACE);               // CR ends an empty first token
      send_beat(1'b0, CH_CR);
      send_beat(1'b0, CH_LF);
      send_beat(1'b0, CH_TAB);
      send_text("test x");
      send_beat(1'b0, CH_LF);
      send_text("tra");                        // NUL in the middle is skipped
      send_beat(1'b0, CH_NUL);
      send_text("in");
      send_beat(1'b0, CH_LF);
      send_text("help");                       // DEL marks the line bad
      send_beat(1'b0, 8'h7F);
      send_beat(1'b0, CH_LF);
      send_beat(1'b0, 8'hFF);
      send_text("vr");
      send_beat(1'b0, CH_LF);
      send_beat(1'b0, 8'h1F);
      send_beat(1'b0, CH_LF);
      send_text("load");
      send_beat(1'b0, CH_CR);
      send_beat(1'b0, CH_LF);
      send_text("sigtrainx");                  // one past the keyword
      send_beat(1'b0, CH_LF);
   endtask

   task automatic test_long_line();
      repeat (LINE_LIMIT - 1)
         send_beat(1'b0, "a");                 // longest line still reported
      send_beat(1'b0, CH_LF);
      repeat (LINE_LIMIT)
         send_beat(1'b0, "b");                 // dropped, no result
      send_text("vr");
      send_beat(1'b0, CH_LF);
   endtask

   task automatic test_idle_timeout();
      write_timeout(16'd1);
      send_text("tr");
      send_ticks(2);                           // second tick clears the line
      send_text("vr");
      send_beat(1'b0, CH_LF);
      send_text("lo");
      send_ticks(1);
      send_text("ad");
      send_beat(1'b0, CH_LF);
      write_timeout(16'hFFFF);                 // never times out
      send_text("he");
      send_ticks(30);
      send_text("lp");
      send_beat(1'b0, CH_LF);
      write_timeout(16'd100);
      send_text("cl");
      send_ticks(101);
      send_text("ear");
      send_beat(1'b0, CH_LF);
   endtask

   task automatic test_random_traffic();
      int stop_at, lines;
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  write_timeout(16'd100); end
            1: begin send_idle_pct = 61; recv_stall_pct = 0;
                     write_timeout(16'($urandom_range(1, 6))); end
            2: begin send_idle_pct = 0;  recv_stall_pct = 61; write_timeout(16'hFFFF); end
            default: begin send_idle_pct = 35; recv_stall_pct = 35;
                     write_timeout(16'($urandom_range(7, 40))); end
         endcase
         stop_at = beats_sent + PHASE_BEATS;
         lines = 0;
         while (beats_sent < stop_at) begin
            send_random_line();
            lines++;
            if (lines % 4 == 0)
               wait_for_results();             // sender backs off completely
         end
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      track_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      track_reset();

      test_keyword_table();
      test_line_forms();
      test_long_line();
      test_idle_timeout();
      test_random_traffic();

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #6000000;
      $display("status: fail");
      $finish;
   end

endmodule
